[hw/rtl/mkd_pkg.sv]
// Shared types, codes and helpers for the multi-key press event detector.
`timescale 1ns / 1ps

package mkd_pkg;

   localparam int NUM_KEYS_DEFAULT    = 5;
   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH         = 4;
   localparam int REG_WIDTH           = 16;
   localparam int TIME_WIDTH          = 32;
   localparam int TWO_PRESS_BIT       = 15;
   localparam int LAST_ENABLE_BIT     = 14;

   localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
   localparam logic [1:0] REG_LONG_PRESS = 2'd1;
   localparam logic [1:0] REG_REPEAT     = 2'd2;
   localparam logic [1:0] REG_ENABLES    = 2'd3;

   localparam logic [2:0] EV_NONE   = 3'd0;
   localparam logic [2:0] EV_SHORT  = 3'd1;
   localparam logic [2:0] EV_LONG   = 3'd2;
   localparam logic [2:0] EV_REPEAT = 3'd3;
   localparam logic [2:0] EV_TWO    = 3'd4;

   localparam int EN_SHORT  = 0;
   localparam int EN_LONG   = 1;
   localparam int EN_REPEAT = 2;

   typedef enum logic [1:0] {
      PH_OFF    = 2'd0,
      PH_TO_ON  = 2'd1,
      PH_ON     = 2'd2,
      PH_TO_OFF = 2'd3
   } phase_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0] debounce_ms;
      logic [REG_WIDTH-1:0] long_press_ms;
      logic [REG_WIDTH-1:0] repeat_ms;
      logic [REG_WIDTH-1:0] event_enables;
   } cfg_type;

   typedef struct packed {
      logic       active_claimed;
      logic [2:0] active_key;
      logic       partner_claimed;
      logic [2:0] partner_key;
   } claim_type;

   typedef struct packed {
      logic [2:0]  key_index;
      logic [2:0]  event_kind;
      logic [15:0] repeat_count;
      logic [2:0]  partner_key;
   } result_type;

   typedef struct packed {
      logic [1:0] n;
      result_type e0;
      result_type e1;
   } result_list_type;

   function automatic result_list_type res_append(result_list_type l, result_type r);
      result_list_type o;
      o = l;
      if (l.n == 2'd0) begin
         o.e0 = r;
         o.n  = 2'd1;
      end else if (l.n == 2'd1) begin
         o.e1 = r;
         o.n  = 2'd2;
      end
      return o;
   endfunction

   function automatic logic event_enabled(logic [REG_WIDTH-1:0] en, int pos);
      if (pos > LAST_ENABLE_BIT || pos < 0) return 1'b0;
      return en[pos[3:0]];
   endfunction

   // deadline reached when (now - deadline) mod 2^32 is below 2^31
   function automatic logic deadline_reached(logic [TIME_WIDTH-1:0] now,
                                             logic [TIME_WIDTH-1:0] deadline);
      logic [TIME_WIDTH-1:0] diff;
      diff = now - deadline;
      return ~diff[TIME_WIDTH-1];
   endfunction

endpackage

[hw/rtl/mkd_cell.sv]
// One key's debounce and event cell; claims, count and results pass through it.
`timescale 1ns / 1ps

module mkd_cell
   import mkd_pkg::*;
#(
   parameter int KEY_INDEX   = 0,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [TIME_WIDTH-1:0]  now_ms,
   input  logic                   key_on,
   input  cfg_type                cfg,
   input  claim_type              claim_in,
   input  logic [COUNT_WIDTH-1:0] count_in,
   input  result_list_type        res_in,
   output claim_type              claim_out,
   output logic [COUNT_WIDTH-1:0] count_out,
   output result_list_type        res_out,
   output logic                   settled_on
);

   localparam logic [2:0] KEY_ID = 3'(KEY_INDEX);

   phase_type             phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] deadline_ff, deadline_in;
   logic                  may_ff, may_in;

   logic       due, is_active, count_zero;
   logic       short_en, long_en, repeat_en, two_en;
   result_type ev;

   assign due        = deadline_reached(now_ms, deadline_ff);
   assign is_active  = claim_in.active_claimed && (claim_in.active_key == KEY_ID);
   assign count_zero = (count_in == '0);
   assign short_en   = event_enabled(cfg.event_enables, 3 * KEY_INDEX + EN_SHORT);
   assign long_en    = event_enabled(cfg.event_enables, 3 * KEY_INDEX + EN_LONG);
   assign repeat_en  = event_enabled(cfg.event_enables, 3 * KEY_INDEX + EN_REPEAT);
   assign two_en     = cfg.event_enables[TWO_PRESS_BIT];

   always_comb begin
      phase_in    = phase_ff;
      deadline_in = deadline_ff;
      may_in      = may_ff;
      claim_out   = claim_in;
      count_out   = count_in;
      res_out     = res_in;
      ev          = '0;
      ev.key_index = KEY_ID;
      unique case (phase_ff)
         PH_OFF: begin
            if (key_on) begin
               phase_in    = PH_TO_ON;
               deadline_in = now_ms + TIME_WIDTH'(cfg.debounce_ms);
            end
         end
         PH_TO_ON: begin
            if (due) begin
               if (key_on) begin
                  phase_in    = PH_ON;
                  deadline_in = now_ms + TIME_WIDTH'(cfg.long_press_ms);
                  if (!claim_in.active_claimed) begin
                     claim_out.active_claimed = 1'b1;
                     claim_out.active_key     = KEY_ID;
                  end else if (!claim_in.partner_claimed) begin
                     claim_out.partner_claimed = 1'b1;
                     claim_out.partner_key     = KEY_ID;
                  end
                  may_in = claim_out.active_claimed && (claim_out.active_key == KEY_ID);
               end else begin
                  phase_in = PH_OFF;
               end
            end
         end
         PH_ON: begin
            if (!key_on) begin
               phase_in    = PH_TO_OFF;
               deadline_in = now_ms + TIME_WIDTH'(cfg.debounce_ms);
            end else if (due) begin
               deadline_in = now_ms + TIME_WIDTH'(cfg.repeat_ms);
               if (may_ff) begin
                  if (long_en && count_zero) begin
                     ev.event_kind = EV_LONG;
                     res_out = res_append(res_out, ev);
                  end
                  if (repeat_en) begin
                     ev.event_kind   = EV_REPEAT;
                     ev.repeat_count = 16'(count_in);
                     res_out = res_append(res_out, ev);
                  end
                  count_out = COUNT_WIDTH'(count_in + 1'b1);
               end
            end else if (may_ff && claim_in.partner_claimed && count_zero && two_en) begin
               ev.event_kind  = EV_TWO;
               ev.partner_key = claim_in.partner_key;
               res_out = res_append(res_out, ev);
               may_in  = 1'b0;
            end
         end
         PH_TO_OFF: begin
            if (due) begin
               if (!key_on) begin
                  phase_in = PH_OFF;
                  if (may_ff && short_en && count_zero) begin
                     ev.event_kind = EV_SHORT;
                     res_out = res_append(res_out, ev);
                  end
                  if (is_active) begin
                     count_out = '0;
                     claim_out = '0;
                  end
               end else begin
                  phase_in = PH_ON;
               end
            end
         end
         default: phase_in = PH_OFF;
      endcase
   end

   assign settled_on = (phase_in == PH_ON);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_OFF;
         deadline_ff <= '0;
         may_ff      <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         deadline_ff <= deadline_in;
         may_ff      <= may_in;
      end
   end

endmodule

[hw/rtl/mkd_out_queue.sv]
// Result queue: takes one or two entries per request, hands out one per cycle while out_ready is high.
`timescale 1ns / 1ps

module mkd_out_queue
   import mkd_pkg::*;
#(
   parameter int DEPTH   = QUEUE_DEPTH,
   parameter int ENTRY_W = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         push_n,
   input  logic [ENTRY_W-1:0] push_e0,
   input  logic [ENTRY_W-1:0] push_e1,
   output logic               space_ok,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [ENTRY_W-1:0] out_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [ENTRY_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_entry = mem_ff[rd_ptr_ff];
   assign space_ok  = (count_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem_ff[wr_ptr_ff] <= push_e0;
      if (push_n == 2'd2) mem_ff[PTR_W'(wr_ptr_ff + 1'b1)] <= push_e1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue overfilled");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |=> out_valid)
      else $error("pushed result not presented");

   a_push_space: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |-> space_ok)
      else $error("push without room");

endmodule

[hw/rtl/multi_key_press_event_detector_top.sv]
// Top level of the multi-key press event detector: config, key cell chain, result queue.
//
// Usage:
//   req channel: one request per sample. req_tdata holds now_ms (bits 31:0) and
//   key_bits above it (MSB = left key, LSB = select key).
//   rsp channel: one or two results per sample; rsp_tlast marks the last one.
//   rsp_tuser carries event_kind, rsp_tdata the other result fields.
//   csr port: single-cycle writes of debounce, long press, repeat and enables.
// Timing:
//   All key cells are chained combinationally, so a sample is taken every
//   cycle while the four-entry result queue has room for two results.
//   Results are registered in the result queue before they appear on rsp.
//   The results of a sample causing two are handed out one at a time on the
//   single rsp port, so a run of such samples is throttled by that port.
// Reset: all keys off, claims and count cleared, registers at their defaults,
//   queue empty. When rsp stalls, results wait in the queue and req_tready
//   drops once fewer than two entries are free.
`timescale 1ns / 1ps

module multi_key_press_event_detector_top
   import mkd_pkg::*;
#(
   parameter int NUM_KEYS    = NUM_KEYS_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // fields from bit 0: now_ms[31:0], key_bits[NUM_KEYS-1:0], zero fill
   input  logic [((TIME_WIDTH+NUM_KEYS+7)/8)*8-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // fields from bit 0: key_index[2:0], repeat_count[15:0], partner_key[2:0],
   // pressed_mask[NUM_KEYS-1:0], zero fill
   output logic [((22+NUM_KEYS+7)/8)*8-1:0] rsp_tdata,
   // fields from bit 0: event_kind[2:0]
   output logic [2:0]             rsp_tuser,
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [REG_WIDTH-1:0]   csr_wdata
);

   localparam int RSP_W   = ((22 + NUM_KEYS + 7) / 8) * 8;
   localparam int FIELD_W = 22 + NUM_KEYS;
   localparam int ENTRY_W = FIELD_W + 3 + 1;

   cfg_type                cfg_ff;
   claim_type              claim_ff;
   logic [COUNT_WIDTH-1:0] count_ff;

   claim_type              claim_chain [NUM_KEYS+1];
   logic [COUNT_WIDTH-1:0] count_chain [NUM_KEYS+1];
   result_list_type        res_chain   [NUM_KEYS+1];

   logic [TIME_WIDTH-1:0]  now_ms;
   logic [NUM_KEYS-1:0]    key_bits, pressed_mask;
   logic                   step;
   result_list_type        res_final;
   result_type             r0, r1;
   logic [1:0]             push_n;
   logic [ENTRY_W-1:0]     push_e0, push_e1, out_entry;
   logic [FIELD_W-1:0]     out_fields;

   assign now_ms   = req_tdata[TIME_WIDTH-1:0];
   assign key_bits = req_tdata[TIME_WIDTH +: NUM_KEYS];
   assign step     = req_tvalid && req_tready;

   assign claim_chain[0] = claim_ff;
   assign count_chain[0] = count_ff;
   assign res_chain[0]   = '0;

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_cell
      mkd_cell #(
         .KEY_INDEX   (k),
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .step       (step),
         .now_ms     (now_ms),
         .key_on     (key_bits[NUM_KEYS-1-k]),
         .cfg        (cfg_ff),
         .claim_in   (claim_chain[k]),
         .count_in   (count_chain[k]),
         .res_in     (res_chain[k]),
         .claim_out  (claim_chain[k+1]),
         .count_out  (count_chain[k+1]),
         .res_out    (res_chain[k+1]),
         .settled_on (pressed_mask[NUM_KEYS-1-k])
      );
   end

   assign res_final = res_chain[NUM_KEYS];

   always_comb begin
      r0 = res_final.e0;
      r1 = res_final.e1;
      if (res_final.n == 2'd0) begin
         r0     = '0;
         push_n = 2'd1;
      end else begin
         push_n = res_final.n;
      end
      if (!step) push_n = 2'd0;
      push_e0 = {(push_n == 2'd1), r0.event_kind, pressed_mask,
                 r0.partner_key, r0.repeat_count, r0.key_index};
      push_e1 = {1'b1, r1.event_kind, pressed_mask,
                 r1.partner_key, r1.repeat_count, r1.key_index};
   end

   mkd_out_queue #(
      .DEPTH   (QUEUE_DEPTH),
      .ENTRY_W (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_e0   (push_e0),
      .push_e1   (push_e1),
      .space_ok  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_entry (out_entry)
   );

   assign out_fields = out_entry[FIELD_W-1:0];
   assign rsp_tuser  = out_entry[FIELD_W +: 3];
   assign rsp_tlast  = out_entry[ENTRY_W-1];
   assign rsp_tdata  = RSP_W'(out_fields);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= 16'd50;
         cfg_ff.long_press_ms <= 16'd1000;
         cfg_ff.repeat_ms     <= 16'd250;
         cfg_ff.event_enables <= 16'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DEBOUNCE:   cfg_ff.debounce_ms   <= csr_wdata;
            REG_LONG_PRESS: cfg_ff.long_press_ms <= csr_wdata;
            REG_REPEAT:     cfg_ff.repeat_ms     <= csr_wdata;
            REG_ENABLES:    cfg_ff.event_enables <= csr_wdata;
            default:        cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         claim_ff <= '0;
         count_ff <= '0;
      end else if (step) begin
         claim_ff <= claim_chain[NUM_KEYS];
         count_ff <= count_chain[NUM_KEYS];
      end
   end

   a_partner_needs_active: assert property (@(posedge clock) disable iff (reset)
      claim_ff.partner_claimed |-> claim_ff.active_claimed)
      else $error("partner claimed without active key");

   a_distinct_claims: assert property (@(posedge clock) disable iff (reset)
      claim_ff.partner_claimed |-> (claim_ff.partner_key != claim_ff.active_key))
      else $error("partner equals active key");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(claim_ff) && $stable(count_ff)))
      else $error("shared state changed without request");

endmodule
